[rtl/rgb_fade_via_hsv_core_assert.svh]
// Assertion macros used by the checker file of the color fade block.
`ifndef RGB_FADE_VIA_HSV_CORE_ASSERT_SVH
`define RGB_FADE_VIA_HSV_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define RGBF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgbf assertion failed");

// Next-cycle implication, off while reset is held.
`define RGBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgbf assertion failed");

// Next-cycle implication that also holds across reset.
`define RGBF_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rgbf assertion failed");

`endif

[rtl/rgbf_pkg.sv]
// Types and constants of the RGB fade through HSV block.
`timescale 1ns / 1ps
package rgbf_pkg;

    localparam int PROGRESS_FRAC_BITS = 10;
    localparam int P_HALF             = 1 << (PROGRESS_FRAC_BITS - 1);
    // smallest progress with progress * 1000 >= 999 * 2^F
    localparam int NEAR_P = (999 * (1 << PROGRESS_FRAC_BITS) + 999) / 1000;

    localparam int ONE_Q16  = 65536;
    localparam int SIX_Q16  = 6 * ONE_Q16;
    localparam int FOUR_Q16 = 4 * ONE_Q16;

    // pipelined divider geometry
    localparam int DIV_NW = 28;
    localparam int DIV_DW = 9;
    localparam int DIV_QW = 19;

    localparam int LAT = 1 + DIV_QW + 6;

    typedef struct packed {
        logic [7:0]  from_red;
        logic [7:0]  from_green;
        logic [7:0]  from_blue;
        logic [7:0]  to_red;
        logic [7:0]  to_green;
        logic [7:0]  to_blue;
        logic [10:0] progress;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out;

    typedef struct packed {
        logic [DIV_NW-1:0] num_h;
        logic [DIV_DW-1:0] den_h;
        logic [DIV_NW-1:0] num_s;
        logic [DIV_DW-1:0] den_s;
        logic              zero;
        logic [16:0]       v;
    } t_prep;

    typedef struct packed {
        logic        near;
        t_out        tgt;
        logic [10:0] p;
        logic        zero_f;
        logic        zero_t;
        logic [16:0] v_f;
        logic [16:0] v_t;
    } t_side;

    typedef struct packed {
        logic near;
        t_out tgt;
    } t_pass;

endpackage

[rtl/rgbf_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rgbf_div import rgbf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_QW-1:0] o_quo
);

    // quotient must fit DIV_QW bits, so the top bits start below the divisor
    logic [DIV_DW-1:0] r_rem [DIV_QW];
    logic [DIV_DW-1:0] r_den [DIV_QW];
    logic [DIV_NW-1:0] r_num [DIV_QW];
    logic [DIV_QW-1:0] r_quo [DIV_QW];

    for (genvar i = 0; i < DIV_QW; i++) begin : g_stage
        logic [DIV_DW-1:0] rem_in;
        logic [DIV_DW-1:0] den_in;
        logic [DIV_NW-1:0] num_in;
        logic [DIV_QW-1:0] quo_in;
        logic [DIV_DW:0]   trial;
        logic              qbit;

        if (i == 0) begin : g_first
            assign rem_in = i_num[DIV_NW-1:DIV_QW];
            assign den_in = i_den;
            assign num_in = i_num;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign den_in = r_den[i-1];
            assign num_in = r_num[i-1];
            assign quo_in = r_quo[i-1];
        end

        assign trial = {rem_in, num_in[DIV_QW-1-i]};
        assign qbit  = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= qbit ? DIV_DW'(trial - {1'b0, den_in}) : trial[DIV_DW-1:0];
                r_den[i] <= den_in;
                r_num[i] <= num_in;
                r_quo[i] <= {quo_in[DIV_QW-2:0], qbit};
            end
        end
    end

    assign o_quo = r_quo[DIV_QW-1];

endmodule

[rtl/rgb_fade_via_hsv_core.sv]
// RGB color fade through HSV space, fully pipelined.
// Stages: 1 prep stage, 19 divider stages, 2 blend stages, 4 HSV-to-RGB stages.
// Throughput: one item per cycle while no result is stalled; the 19-stage
// restoring dividers set the depth.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits; data regs are not reset.
`timescale 1ns / 1ps
module rgb_fade_via_hsv_core import rgbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // ---------------------------------------------------------------
    // Pipeline control: one valid bit per stage, global freeze on stall
    // ---------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en          = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // ---------------------------------------------------------------
    // Stage A: max/min, sector numerators and divider operands
    // ---------------------------------------------------------------
    // V = 257*max + (max >= 128): exact round(max * 65536 / 255)
    function automatic t_prep hsv_prep(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [7:0]  d;
        logic [10:0] nh;
        t_prep       o;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (r == mx) begin
            nh = (g >= b) ? 11'(g - b) : 11'(11'(d) * 11'd6 - 11'(b - g));
        end else if (g == mx) begin
            nh = (b >= r) ? 11'(11'(d) * 11'd2 + 11'(b - r))
                          : 11'(11'(d) * 11'd2 - 11'(r - b));
        end else begin
            nh = (r >= g) ? 11'(11'(d) * 11'd4 + 11'(r - g))
                          : 11'(11'(d) * 11'd4 - 11'(g - r));
        end
        o.num_h = {nh, 17'd0} + DIV_NW'(d);
        o.den_h = {d, 1'b0};
        o.num_s = {3'd0, d, 17'd0} + DIV_NW'(mx);
        o.den_s = {mx, 1'b0};
        o.zero  = (d == 8'd0);
        o.v     = {1'b0, mx, 8'd0} + 17'(mx) + 17'(mx[7]);
        return o;
    endfunction

    t_prep r_a_f;
    t_prep r_a_t;
    t_side r_a_side;
    t_prep n_a_f;
    t_prep n_a_t;

    assign n_a_f = hsv_prep(i_in_data.from_red, i_in_data.from_green, i_in_data.from_blue);
    assign n_a_t = hsv_prep(i_in_data.to_red, i_in_data.to_green, i_in_data.to_blue);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_f                  <= n_a_f;
            r_a_t                  <= n_a_t;
            r_a_side.near          <= (i_in_data.progress >= 11'(NEAR_P));
            r_a_side.tgt.out_red   <= i_in_data.to_red;
            r_a_side.tgt.out_green <= i_in_data.to_green;
            r_a_side.tgt.out_blue  <= i_in_data.to_blue;
            r_a_side.p             <= i_in_data.progress;
            r_a_side.zero_f        <= n_a_f.zero;
            r_a_side.zero_t        <= n_a_t.zero;
            r_a_side.v_f           <= n_a_f.v;
            r_a_side.v_t           <= n_a_t.v;
        end
    end

    // ---------------------------------------------------------------
    // Divider stages: hue and saturation of both colors
    // ---------------------------------------------------------------
    logic [DIV_QW-1:0] q_h_f;
    logic [DIV_QW-1:0] q_h_t;
    logic [DIV_QW-1:0] q_s_f;
    logic [DIV_QW-1:0] q_s_t;

    rgbf_div u_div_hf (.i_clk(i_clk), .i_en(en), .i_num(r_a_f.num_h),
                       .i_den(r_a_f.den_h), .o_quo(q_h_f));
    rgbf_div u_div_ht (.i_clk(i_clk), .i_en(en), .i_num(r_a_t.num_h),
                       .i_den(r_a_t.den_h), .o_quo(q_h_t));
    rgbf_div u_div_sf (.i_clk(i_clk), .i_en(en), .i_num(r_a_f.num_s),
                       .i_den(r_a_f.den_s), .o_quo(q_s_f));
    rgbf_div u_div_st (.i_clk(i_clk), .i_en(en), .i_num(r_a_t.num_s),
                       .i_den(r_a_t.den_s), .o_quo(q_s_t));

    // sideband delay line matching the divider depth
    t_side r_d_side [DIV_QW];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side[0] <= r_a_side;
            for (int i = 1; i < DIV_QW; i++) begin
                r_d_side[i] <= r_d_side[i-1];
            end
        end
    end

    t_side d_side;
    assign d_side = r_d_side[DIV_QW-1];

    // grey or black: hue and saturation are zero; hue wraps into [0, 6)
    function automatic logic [18:0] hue_fix(input logic [18:0] q, input logic zero);
        logic [18:0] h;
        h = (q >= 19'(SIX_Q16)) ? 19'(q - 19'(SIX_Q16)) : q;
        return zero ? 19'd0 : h;
    endfunction

    logic [18:0] h_f;
    logic [18:0] h_t;
    logic [16:0] s_f;
    logic [16:0] s_t;

    assign h_f = hue_fix(q_h_f, d_side.zero_f);
    assign h_t = hue_fix(q_h_t, d_side.zero_t);
    assign s_f = d_side.zero_f ? 17'd0 : q_s_f[16:0];
    assign s_t = d_side.zero_t ? 17'd0 : q_s_t[16:0];

    // ---------------------------------------------------------------
    // Blend: X = a + round((b - a) * p / 2^F), one multiply per field
    // ---------------------------------------------------------------
    t_pass              r_ps [5];
    logic signed [31:0] r_b1_prod_h;
    logic signed [29:0] r_b1_prod_s;
    logic signed [29:0] r_b1_prod_v;
    logic [18:0]        r_b1_a_h;
    logic [16:0]        r_b1_a_s;
    logic [16:0]        r_b1_a_v;

    logic signed [11:0] p_s;
    assign p_s = signed'({1'b0, d_side.p});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_prod_h <= 32'(signed'(20'(h_t) - 20'(h_f)) * p_s);
            r_b1_prod_s <= 30'(signed'(18'(s_t) - 18'(s_f)) * p_s);
            r_b1_prod_v <= 30'(signed'(18'(d_side.v_t) - 18'(d_side.v_f)) * p_s);
            r_b1_a_h    <= h_f;
            r_b1_a_s    <= s_f;
            r_b1_a_v    <= d_side.v_f;
            r_ps[0].near <= d_side.near;
            r_ps[0].tgt  <= d_side.tgt;
            for (int i = 1; i < 5; i++) begin
                r_ps[i] <= r_ps[i-1];
            end
        end
    end

    logic signed [32:0] acc_h;
    logic signed [32:0] acc_s;
    logic signed [32:0] acc_v;
    logic [18:0]        m_h;
    logic [16:0]        m_s;
    logic [16:0]        m_v;

    assign acc_h = 33'(signed'({1'b0, r_b1_a_h}))
                 + ((33'(r_b1_prod_h) + 33'(P_HALF)) >>> PROGRESS_FRAC_BITS);
    assign acc_s = 33'(signed'({1'b0, r_b1_a_s}))
                 + ((33'(r_b1_prod_s) + 33'(P_HALF)) >>> PROGRESS_FRAC_BITS);
    assign acc_v = 33'(signed'({1'b0, r_b1_a_v}))
                 + ((33'(r_b1_prod_v) + 33'(P_HALF)) >>> PROGRESS_FRAC_BITS);

    assign m_h = (acc_h[18:0] >= 19'(SIX_Q16)) ? 19'(acc_h[18:0] - 19'(SIX_Q16))
                                               : acc_h[18:0];
    assign m_s = (acc_s[17:0] > 18'(ONE_Q16)) ? 17'(ONE_Q16) : acc_s[16:0];
    assign m_v = (acc_v[17:0] > 18'(ONE_Q16)) ? 17'(ONE_Q16) : acc_v[16:0];

    logic [18:0] r_b2_h;
    logic [16:0] r_b2_s;
    logic [16:0] r_b2_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b2_h <= m_h;
            r_b2_s <= m_s;
            r_b2_v <= m_v;
        end
    end

    // ---------------------------------------------------------------
    // HSV to RGB: channel = 255 * (V - V*S*t), rounded half to even
    // ---------------------------------------------------------------
    localparam int CH_N [3] = '{5, 3, 1};   // red, green, blue

    function automatic logic [16:0] chan_t(input logic [18:0] k);
        logic [18:0] t;
        if (k >= 19'(FOUR_Q16)) begin
            t = 19'd0;
        end else begin
            t = 19'(FOUR_Q16) - k;
            if (k < t) t = k;
            if (t > 19'(ONE_Q16)) t = 19'(ONE_Q16);
        end
        return t[16:0];
    endfunction

    logic [33:0] r_c1_vs;
    logic [16:0] r_c1_v;
    logic [16:0] r_c1_t [3];
    logic [33:0] r_c2_vs;
    logic [16:0] r_c2_v;
    logic        r_c2_tfull [3];
    logic [32:0] r_c2_pl [3];
    logic [32:0] r_c2_ph [3];
    logic [48:0] r_c3_x [3];
    t_out        r_out;

    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [19:0] k_raw;
        logic [18:0] k;
        logic [49:0] vst;
        logic [49:0] x_full;
        logic [56:0] num;
        logic [8:0]  q;
        logic        rup;
        logic [8:0]  qr;

        assign k_raw = (20'(CH_N[c]) << 16) + 20'(r_b2_h);
        assign k     = (k_raw >= 20'(SIX_Q16)) ? 19'(k_raw - 20'(SIX_Q16)) : k_raw[18:0];

        assign vst    = r_c2_tfull[c] ? {r_c2_vs, 16'd0}
                                      : ({r_c2_ph[c], 17'd0} + 50'(r_c2_pl[c]));
        assign x_full = {1'b0, r_c2_v, 32'd0} - vst;

        assign num = {r_c3_x[c], 8'd0} - {8'd0, r_c3_x[c]};
        assign q   = num[56:48];
        assign rup = num[47] && ((|num[46:0]) || q[0]);
        assign qr  = q + 9'(rup);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c1_t[c]     <= chan_t(k);
                r_c2_tfull[c] <= r_c1_t[c][16];
                r_c2_pl[c]    <= r_c1_vs[16:0] * r_c1_t[c][15:0];
                r_c2_ph[c]    <= r_c1_vs[33:17] * r_c1_t[c][15:0];
                r_c3_x[c]     <= x_full[48:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_vs <= r_b2_v * r_b2_s;
            r_c1_v  <= r_b2_v;
            r_c2_vs <= r_c1_vs;
            r_c2_v  <= r_c1_v;
        end
    end

    // output register; near the target the target color passes unchanged
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_ps[4].near) begin
                r_out <= r_ps[4].tgt;
            end else begin
                r_out.out_red   <= (g_ch[0].qr > 9'd255) ? 8'd255 : g_ch[0].qr[7:0];
                r_out.out_green <= (g_ch[1].qr > 9'd255) ? 8'd255 : g_ch[1].qr[7:0];
                r_out.out_blue  <= (g_ch[2].qr > 9'd255) ? 8'd255 : g_ch[2].qr[7:0];
            end
        end
    end

    assign o_out_data = r_out;

endmodule

[rtl/rgbf_chk.sv]
// Port-level checker for the color fade block, bound to the top level.
`timescale 1ns / 1ps
`include "rgb_fade_via_hsv_core_assert.svh"
module rgbf_chk import rgbf_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // input side stalls exactly when a result waits on a stalled receiver
    `RGBF_ASSERT_IMPL(a_stall_link, 1'b1, o_in_stall == (o_out_valid && i_out_stall))

    // reset empties the pipeline
    `RGBF_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid)

    // a stalled result stays put
    `RGBF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
                      o_out_valid && $stable(o_out_data))

    // a stalled input item stays put
    `RGBF_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall,
                      i_in_valid && $stable(i_in_data))

endmodule

bind rgb_fade_via_hsv_core rgbf_chk u_rgbf_chk (.*);

[tb/tb_top.sv]
// Self-checking testbench for the RGB fade through HSV core.
`timescale 1ns / 1ps
module tb_top;
    import rgbf_pkg::*;

    localparam int N_RANDOM = 1530;

    // HSV triple in Q16; hue counted in sextants
    typedef struct {
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
    } t_hsv;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    rgb_fade_via_hsv_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    t_in  pending_items[$];
    t_out expected_colors[$];
    int   mismatch_count;
    bit   stimulus_done;
    int   hold_off_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Color to HSV, fixed point with round-half-up divisions.
    function automatic t_hsv color_to_hsv(longint unsigned r, longint unsigned g,
                                          longint unsigned b);
        t_hsv o;
        longint unsigned mx, mn, d, num;
        o = '{0, 0, 0};
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (mx == 0) return o;
        o.v = (mx * ONE_Q16 * 2 + 255) / 510;
        d = mx - mn;
        if (d == 0) return o;
        o.s = (d * ONE_Q16 * 2 + mx) / (2 * mx);
        if (r == mx) begin
            if (g >= b) num = (g - b) * ONE_Q16;
            else num = SIX_Q16 * d - (b - g) * ONE_Q16;
        end else if (g == mx) begin
            if (b >= r) num = 2 * ONE_Q16 * d + (b - r) * ONE_Q16;
            else num = 2 * ONE_Q16 * d - (r - b) * ONE_Q16;
        end else begin
            if (r >= g) num = 4 * ONE_Q16 * d + (r - g) * ONE_Q16;
            else num = 4 * ONE_Q16 * d - (g - r) * ONE_Q16;
        end
        o.h = ((2 * num + d) / (2 * d)) % SIX_Q16;
        return o;
    endfunction

    function automatic longint unsigned mix_q16(longint unsigned a, longint unsigned b,
                                                longint unsigned p);
        longint unsigned one;
        one = 64'd1 << PROGRESS_FRAC_BITS;
        return (a * (one - p) + b * p + (one >> 1)) >> PROGRESS_FRAC_BITS;
    endfunction

    // One RGB channel from HSV; n is the sextant offset (5 red, 3 green, 1 blue).
    function automatic logic [7:0] hsv_channel(longint unsigned n, t_hsv c);
        longint unsigned k, t, num, q, rem;
        k = (n * ONE_Q16 + c.h) % SIX_Q16;
        if (k >= FOUR_Q16) t = 0;
        else begin
            t = FOUR_Q16 - k;
            if (k < t) t = k;
            if (t > ONE_Q16) t = ONE_Q16;
        end
        num = 255 * ((c.v << 32) - c.v * c.s * t);
        q = num >> 48;
        rem = num & ((64'd1 << 48) - 1);
        // ties to even
        if (rem > (64'd1 << 47) || (rem == (64'd1 << 47) && q[0])) q++;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic t_out fade_color(t_in x);
        t_out o;
        t_hsv a, b, m;
        longint unsigned p;
        p = x.progress;
        // near the target the target color passes through untouched
        if (p * 1000 >= (64'd999 << PROGRESS_FRAC_BITS)) begin
            o.out_red = x.to_red;
            o.out_green = x.to_green;
            o.out_blue = x.to_blue;
            return o;
        end
        a = color_to_hsv(x.from_red, x.from_green, x.from_blue);
        b = color_to_hsv(x.to_red, x.to_green, x.to_blue);
        m.h = mix_q16(a.h, b.h, p) % SIX_Q16;
        m.s = mix_q16(a.s, b.s, p);
        m.v = mix_q16(a.v, b.v, p);
        if (m.s > ONE_Q16) m.s = ONE_Q16;
        if (m.v > ONE_Q16) m.v = ONE_Q16;
        o.out_red = hsv_channel(5, m);
        o.out_green = hsv_channel(3, m);
        o.out_blue = hsv_channel(1, m);
        return o;
    endfunction

    function automatic t_in make_item(logic [7:0] fr, logic [7:0] fg, logic [7:0] fb,
                                      logic [7:0] tr, logic [7:0] tg, logic [7:0] tb,
                                      logic [10:0] p);
        t_in x;
        x.from_red = fr;
        x.from_green = fg;
        x.from_blue = fb;
        x.to_red = tr;
        x.to_green = tg;
        x.to_blue = tb;
        x.progress = p;
        return x;
    endfunction

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Directed corners, then random fades.
    initial begin
        t_in x;
        int  sel;
        pending_items.push_back(make_item(0, 0, 0, 255, 255, 255, 0));
        pending_items.push_back(make_item(255, 255, 255, 0, 0, 0, 512));
        pending_items.push_back(make_item(255, 0, 0, 0, 0, 255, 512));
        pending_items.push_back(make_item(0, 255, 0, 255, 0, 0, 300));
        pending_items.push_back(make_item(0, 0, 255, 0, 255, 0, 700));
        pending_items.push_back(make_item(255, 0, 10, 10, 200, 0, 100));
        pending_items.push_back(make_item(128, 128, 128, 40, 40, 40, 256));
        pending_items.push_back(make_item(200, 30, 255, 255, 255, 0, 1));
        pending_items.push_back(make_item(17, 99, 201, 250, 5, 77, 1022));
        pending_items.push_back(make_item(17, 99, 201, 250, 5, 77, 1023));
        pending_items.push_back(make_item(17, 99, 201, 250, 5, 77, NEAR_P - 1));
        pending_items.push_back(make_item(17, 99, 201, 250, 5, 77, NEAR_P));
        pending_items.push_back(make_item(17, 99, 201, 250, 5, 77, 1024));
        pending_items.push_back(make_item(17, 99, 201, 250, 5, 77, 11'h7ff));
        pending_items.push_back(make_item(255, 255, 0, 0, 255, 255, 0));
        pending_items.push_back(make_item(255, 0, 255, 1, 0, 0, 1000));
        pending_items.push_back(make_item(1, 1, 0, 0, 1, 1, 512));
        pending_items.push_back(make_item(255, 10, 200, 10, 255, 200, 511));
        for (int i = 0; i < N_RANDOM; i++) begin
            x = make_item(rand_channel(), rand_channel(), rand_channel(),
                          rand_channel(), rand_channel(), rand_channel(), 0);
            sel = $urandom_range(0, 19);
            if (sel == 0) x.progress = 11'($urandom_range(0, 2047));
            else if (sel == 1) x.progress = 11'($urandom_range(1015, 1030));
            else x.progress = 11'($urandom_range(0, 1024));
            pending_items.push_back(x);
        end
    end

    // Driver: gap drawn per item, payload held while stalled.
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= $urandom_range(0, 11);
        end else if (i_in_valid && !o_in_stall) begin
            expected_colors.push_back(fade_color(i_in_data));
            void'(pending_items.pop_front());
            in_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (pending_items.size() > 0 && $urandom_range(0, 1) == 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_items[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (in_gap > 0) in_gap <= in_gap - 1;
            else if (pending_items.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_items[0];
            end
        end
    end

    assign stimulus_done = (pending_items.size() == 0) && !i_in_valid;

    // Long receiver hold-off so the pipeline fills and back-pressures.
    initial begin
        hold_off_cycles = 0;
        wait (i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_off_cycles = 80;
        while (hold_off_cycles > 0) begin
            @(posedge i_clk);
            hold_off_cycles = hold_off_cycles - 1;
        end
    end

    // Monitor: stall drawn per result, compare against oldest expectation.
    int out_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b1;
            out_gap <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_colors.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", o_out_data);
                end else if (o_out_data !== expected_colors[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                                 expected_colors[0].out_red, expected_colors[0].out_green,
                                 expected_colors[0].out_blue, o_out_data.out_red,
                                 o_out_data.out_green, o_out_data.out_blue);
                    void'(expected_colors.pop_front());
                end else begin
                    void'(expected_colors.pop_front());
                end
            end
            if (hold_off_cycles > 1) i_out_stall <= 1'b1;
            else if (o_out_valid && !i_out_stall) begin
                if ($urandom_range(0, 3) == 0) begin
                    out_gap <= 0;
                    i_out_stall <= 1'b0;
                end else begin
                    out_gap <= $urandom_range(0, 11);
                    i_out_stall <= 1'b1;
                end
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        mismatch_count = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b1;
        i_in_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && expected_colors.size() == 0);
        repeat (LAT + 20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_colors.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
